>>> design/scap_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the set-associative cache.
// No dependencies; every other design file refers to this package by scoped names.
package scap_pkg;

   localparam int MAX_WAYS     = 8;
   localparam int MAX_SET_BITS = 10;
   localparam int ADDR_BITS    = 48;

   localparam int SETS      = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W    = WAY_W;
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
   localparam int OLD_W     = RANK_W + 1;
   localparam int SHIFT_W   = 6;
   localparam int CNT_W     = 32;
   localparam int OUT_WAY_W = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, word addressed on paddr[4:2]
   localparam logic [2:0] REG_OFFSET_BITS     = 3'd0;
   localparam logic [2:0] REG_SET_BITS        = 3'd1;
   localparam logic [2:0] REG_WAYS_IN_USE     = 3'd2;
   localparam logic [2:0] REG_POLICY          = 3'd3;
   localparam logic [2:0] REG_PREFETCH_ENABLE = 3'd4;

   localparam logic CMD_WRITE  = 1'b1;
   localparam logic POLICY_LRU = 1'b0;

   typedef struct packed {
      logic [4:0] offset_bits;
      logic [3:0] set_bits;
      logic [3:0] ways_in_use;
      logic       policy;
      logic       prefetch_enable;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] tag;
      logic [RANK_W-1:0]    rank;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef struct packed {
      logic              touch_on_hit;
      logic [WCNT_W-1:0] ways;
   } unit_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             write_en;
   } unit_stat_type;

endpackage

>>> design/scap_if.sv
`timescale 1ns / 1ps
// Access and result channel interfaces (valid/ready beats).
// Depends on scap_pkg for field widths.
interface scap_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [scap_pkg::ADDR_BITS-1:0] address;

   modport source (output valid, output cmd, output address, input ready);
   modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface scap_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [scap_pkg::OUT_WAY_W-1:0] way;
   logic                           prefetch_read;
   logic [scap_pkg::CNT_W-1:0]     total_reads;
   logic [scap_pkg::CNT_W-1:0]     total_writes;
   logic [scap_pkg::CNT_W-1:0]     total_hits;
   logic [scap_pkg::CNT_W-1:0]     total_misses;

   modport source (output valid, output hit, output way, output prefetch_read,
                   output total_reads, output total_writes, output total_hits,
                   output total_misses, input ready);
   modport sink   (input valid, input hit, input way, input prefetch_read,
                   input total_reads, input total_writes, input total_hits,
                   input total_misses, output ready);
endinterface

>>> design/scap_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the cache.
// Depends on scap_pkg.
module scap_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scap_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scap_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scap_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output scap_pkg::cfg_type               cfg
);

   scap_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        idx;
   logic              wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            scap_pkg::REG_OFFSET_BITS:     cfg_in.offset_bits     = csr_pwdata[4:0];
            scap_pkg::REG_SET_BITS:        cfg_in.set_bits        = csr_pwdata[3:0];
            scap_pkg::REG_WAYS_IN_USE:     cfg_in.ways_in_use     = csr_pwdata[3:0];
            scap_pkg::REG_POLICY:          cfg_in.policy          = csr_pwdata[0];
            scap_pkg::REG_PREFETCH_ENABLE: cfg_in.prefetch_enable = csr_pwdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         scap_pkg::REG_OFFSET_BITS:
            csr_prdata = scap_pkg::CSR_DATA_W'(cfg_ff.offset_bits);
         scap_pkg::REG_SET_BITS:
            csr_prdata = scap_pkg::CSR_DATA_W'(cfg_ff.set_bits);
         scap_pkg::REG_WAYS_IN_USE:
            csr_prdata = scap_pkg::CSR_DATA_W'(cfg_ff.ways_in_use);
         scap_pkg::REG_POLICY:
            csr_prdata = scap_pkg::CSR_DATA_W'(cfg_ff.policy);
         scap_pkg::REG_PREFETCH_ENABLE:
            csr_prdata = scap_pkg::CSR_DATA_W'(cfg_ff.prefetch_enable);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits     <= 5'd4;
         cfg_ff.set_bits        <= 4'd0;
         cfg_ff.ways_in_use     <= 4'd1;
         cfg_ff.policy          <= 1'b0;
         cfg_ff.prefetch_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/scap_set_unit.sv
`timescale 1ns / 1ps
// Set update unit: tag lookup, victim choice and recency-rank update of one row.
// Shared by the demand and the prefetch pass. Depends on scap_pkg.
module scap_set_unit (
   input  scap_pkg::row_type                row,
   input  logic [scap_pkg::ADDR_BITS-1:0]   tag,
   input  scap_pkg::unit_ctrl_type          ctrl,
   output scap_pkg::row_type                new_row,
   output scap_pkg::unit_stat_type          stat
);

   logic                          hit;
   logic [scap_pkg::WAY_W-1:0]    hit_way;
   logic                          found_inv;
   logic [scap_pkg::WAY_W-1:0]    inv_way;
   logic [scap_pkg::RANK_W-1:0]   best;
   logic [scap_pkg::WAY_W-1:0]    lru_way;
   logic [scap_pkg::WAY_W-1:0]    sel;
   logic [scap_pkg::OLD_W-1:0]    old;
   logic [scap_pkg::MAX_WAYS-1:0] in_use;

   always_comb begin
      for (int v = 0; v < scap_pkg::MAX_WAYS; v++) begin
         in_use[v] = scap_pkg::WCNT_W'(v) < ctrl.ways;
      end
   end

   always_comb begin
      hit       = 1'b0;
      hit_way   = '0;
      found_inv = 1'b0;
      inv_way   = '0;
      best      = '0;
      lru_way   = '0;
      for (int v = 0; v < scap_pkg::MAX_WAYS; v++) begin
         if (!hit && in_use[v] && row[v].valid && row[v].tag == tag) begin
            hit     = 1'b1;
            hit_way = scap_pkg::WAY_W'(v);
         end
         if (!found_inv && in_use[v] && !row[v].valid) begin
            found_inv = 1'b1;
            inv_way   = scap_pkg::WAY_W'(v);
         end
         // lowest way with the largest rank
         if (in_use[v] && row[v].rank > best) begin
            best    = row[v].rank;
            lru_way = scap_pkg::WAY_W'(v);
         end
      end
   end

   always_comb begin
      if (hit) begin
         sel = hit_way;
      end else if (found_inv) begin
         sel = inv_way;
      end else begin
         sel = lru_way;
      end
      old = row[sel].valid ? {1'b0, row[sel].rank} : scap_pkg::OLD_W'(scap_pkg::MAX_WAYS);
   end

   always_comb begin
      new_row = row;
      for (int v = 0; v < scap_pkg::MAX_WAYS; v++) begin
         if (in_use[v] && scap_pkg::WAY_W'(v) != sel && row[v].valid &&
             {1'b0, row[v].rank} < old && row[v].rank != '1) begin
            new_row[v].rank = row[v].rank + 1'b1;
         end
      end
      new_row[sel].rank = '0;
      if (!hit) begin
         new_row[sel].valid = 1'b1;
         new_row[sel].tag   = tag;
      end
   end

   assign stat.hit      = hit;
   assign stat.way      = sel;
   assign stat.write_en = !hit || ctrl.touch_on_hit;

endmodule

>>> design/set_assoc_cache_with_prefetch_core.sv
`timescale 1ns / 1ps
// Set-associative cache with LRU/FIFO replacement and next-line prefetch.
// States: DREAD and DUPD (plus PREAD and PUPD for a prefetch pass), then DONE, which waits
// for a free result register; a new access is taken only in IDLE. Each pass reads one row
// of the set memory via the shared set unit, and writes it back on a miss or LRU demand hit.
// Reset (synchronous): clears control and counters, then sweeps the 1024-row set memory,
// one row per cycle, before the first access is taken.
module set_assoc_cache_with_prefetch_core (
   input  logic                            clock,
   input  logic                            reset,
   scap_req_if.sink                        req_ch,
   scap_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scap_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scap_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scap_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DREAD = 3'd2;
   localparam logic [2:0] ST_DUPD  = 3'd3;
   localparam logic [2:0] ST_PREAD = 3'd4;
   localparam logic [2:0] ST_PUPD  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam int AW = scap_pkg::ADDR_BITS;
   localparam int SW = scap_pkg::SET_IDX_W;
   localparam int CW = scap_pkg::CNT_W;

   scap_pkg::cfg_type        cfg;
   scap_pkg::row_type        mem [scap_pkg::SETS];
   scap_pkg::row_type        row_ff;
   scap_pkg::row_type        new_row;
   scap_pkg::unit_ctrl_type  uctrl;
   scap_pkg::unit_stat_type  ustat;

   logic [2:0]               state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            na_ff, na_in;
   logic [SW-1:0]            set_ff, set_in;
   logic [AW-1:0]            tag_ff, tag_in;
   logic [SW-1:0]            clr_ff, clr_in;
   logic                     hit_ff, hit_in;
   logic [scap_pkg::WAY_W-1:0] way_ff, way_in;
   logic                     pf_ff, pf_in;
   logic [CW-1:0]            rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0]            wr_cnt_ff, wr_cnt_in;
   logic [CW-1:0]            hit_cnt_ff, hit_cnt_in;
   logic [CW-1:0]            miss_cnt_ff, miss_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     o_hit_ff, o_hit_in;
   logic [scap_pkg::OUT_WAY_W-1:0] o_way_ff, o_way_in;
   logic                     o_pf_ff, o_pf_in;
   logic [CW-1:0]            o_rd_ff, o_rd_in;
   logic [CW-1:0]            o_wr_ff, o_wr_in;
   logic [CW-1:0]            o_hit_cnt_ff, o_hit_cnt_in;
   logic [CW-1:0]            o_miss_ff, o_miss_in;

   logic [3:0]               eff_sb;
   logic [3:0]               eff_ways;
   logic [AW-1:0]            dec_addr;
   logic [AW-1:0]            dec_shift;
   logic [SW-1:0]            set_mask;
   logic [SW-1:0]            dec_set;
   logic [AW-1:0]            dec_tag;
   logic [scap_pkg::SHIFT_W-1:0] tag_shift;
   logic                     mem_we;
   logic [SW-1:0]            mem_waddr;
   scap_pkg::row_type        mem_wdata;
   logic                     req_beat;
   logic                     out_free;

   scap_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // effective geometry
   always_comb begin
      if (cfg.set_bits > 4'(scap_pkg::MAX_SET_BITS)) begin
         eff_sb = 4'(scap_pkg::MAX_SET_BITS);
      end else begin
         eff_sb = cfg.set_bits;
      end
      if (cfg.ways_in_use == 4'd0) begin
         eff_ways = 4'd1;
      end else if (cfg.ways_in_use > 4'(scap_pkg::MAX_WAYS)) begin
         eff_ways = 4'(scap_pkg::MAX_WAYS);
      end else begin
         eff_ways = cfg.ways_in_use;
      end
   end

   // shared address split: demand address, or the next block in the prefetch pass
   assign dec_addr  = (state_ff == ST_PREAD) ? na_ff : addr_ff;
   assign dec_shift = dec_addr >> cfg.offset_bits;
   assign set_mask  = ~({SW{1'b1}} << eff_sb);
   assign dec_set   = dec_shift[SW-1:0] & set_mask;
   assign tag_shift = scap_pkg::SHIFT_W'(cfg.offset_bits) + scap_pkg::SHIFT_W'(eff_sb);
   assign dec_tag   = dec_addr >> tag_shift;

   assign uctrl.touch_on_hit = (state_ff == ST_DUPD) && (cfg.policy == scap_pkg::POLICY_LRU);
   assign uctrl.ways         = scap_pkg::WCNT_W'(eff_ways);

   scap_set_unit u_set_unit (
      .row     (row_ff),
      .tag     (tag_ff),
      .ctrl    (uctrl),
      .new_row (new_row),
      .stat    (ustat)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = new_row;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_DUPD || state_ff == ST_PUPD) begin
         mem_we = ustat.write_en;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      row_ff <= mem[dec_set];
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_beat     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      na_in        = na_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      clr_in       = clr_ff;
      hit_in       = hit_ff;
      way_in       = way_ff;
      pf_in        = pf_ff;
      rd_cnt_in    = rd_cnt_ff;
      wr_cnt_in    = wr_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_hit_in     = o_hit_ff;
      o_way_in     = o_way_ff;
      o_pf_in      = o_pf_ff;
      o_rd_in      = o_rd_ff;
      o_wr_in      = o_wr_ff;
      o_hit_cnt_in = o_hit_cnt_ff;
      o_miss_in    = o_miss_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(scap_pkg::SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               cmd_in   = req_ch.cmd;
               addr_in  = req_ch.address;
               state_in = ST_DREAD;
            end
         end
         ST_DREAD: begin
            set_in   = dec_set;
            tag_in   = dec_tag;
            na_in    = addr_ff + (AW'(1) << cfg.offset_bits);
            state_in = ST_DUPD;
         end
         ST_DUPD: begin
            hit_in = ustat.hit;
            way_in = ustat.way;
            pf_in  = 1'b0;
            if (cmd_ff == scap_pkg::CMD_WRITE && wr_cnt_ff != '1) begin
               wr_cnt_in = wr_cnt_ff + 1'b1;
            end
            if (ustat.hit) begin
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               if (miss_cnt_ff != '1) begin
                  miss_cnt_in = miss_cnt_ff + 1'b1;
               end
               if (rd_cnt_ff != '1) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
               state_in = cfg.prefetch_enable ? ST_PREAD : ST_DONE;
            end
         end
         ST_PREAD: begin
            set_in   = dec_set;
            tag_in   = dec_tag;
            state_in = ST_PUPD;
         end
         ST_PUPD: begin
            if (!ustat.hit) begin
               pf_in = 1'b1;
               if (rd_cnt_ff != '1) begin
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_hit_in     = hit_ff;
               o_way_in     = scap_pkg::OUT_WAY_W'(way_ff);
               o_pf_in      = pf_ff;
               o_rd_in      = rd_cnt_ff;
               o_wr_in      = wr_cnt_ff;
               o_hit_cnt_in = hit_cnt_ff;
               o_miss_in    = miss_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_cnt_ff    <= rd_cnt_in;
         wr_cnt_ff    <= wr_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      na_ff        <= na_in;
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      hit_ff       <= hit_in;
      way_ff       <= way_in;
      pf_ff        <= pf_in;
      o_hit_ff     <= o_hit_in;
      o_way_ff     <= o_way_in;
      o_pf_ff      <= o_pf_in;
      o_rd_ff      <= o_rd_in;
      o_wr_ff      <= o_wr_in;
      o_hit_cnt_ff <= o_hit_cnt_in;
      o_miss_ff    <= o_miss_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = o_hit_ff;
   assign rsp_ch.way           = o_way_ff;
   assign rsp_ch.prefetch_read = o_pf_ff;
   assign rsp_ch.total_reads   = o_rd_ff;
   assign rsp_ch.total_writes  = o_wr_ff;
   assign rsp_ch.total_hits    = o_hit_cnt_ff;
   assign rsp_ch.total_misses  = o_miss_ff;

endmodule

>>> bench/scap_bench_pkg.sv
`timescale 1ns / 1ps
// Access tracker for the set-associative cache bench: predicts the outcome of each
// accepted access and checks result beats against it. Depends on scap_pkg.
package scap_bench_pkg;
   import scap_pkg::*;

   localparam logic CMD_READ    = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;
   localparam int   NUM_LINES   = SETS * MAX_WAYS;

   typedef struct {
      bit                 hit;
      bit [OUT_WAY_W-1:0] way;
      bit                 prefetch_read;
      bit [CNT_W-1:0]     total_reads;
      bit [CNT_W-1:0]     total_writes;
      bit [CNT_W-1:0]     total_hits;
      bit [CNT_W-1:0]     total_misses;
   } access_outcome;

   class cache_tracker;
      bit [4:0]           offset_bits;
      bit [3:0]           set_bits;
      bit [3:0]           ways_in_use;
      bit                 policy;
      bit                 prefetch_enable;
      bit                 line_valid [NUM_LINES];
      bit [ADDR_BITS-1:0] line_tag [NUM_LINES];
      bit [RANK_W-1:0]    line_rank [NUM_LINES];
      bit [CNT_W-1:0]     read_count;
      bit [CNT_W-1:0]     write_count;
      bit [CNT_W-1:0]     hit_count;
      bit [CNT_W-1:0]     miss_count;
      access_outcome      awaited [$];
      int                 failures;

      function new();
         offset_bits     = 5'd4;
         set_bits        = 4'd0;
         ways_in_use     = 4'd1;
         policy          = POLICY_LRU;
         prefetch_enable = 1'b0;
         failures        = 0;
      endfunction

      function void apply_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_OFFSET_BITS:     offset_bits     = value[4:0];
            REG_SET_BITS:        set_bits        = value[3:0];
            REG_WAYS_IN_USE:     ways_in_use     = value[3:0];
            REG_POLICY:          policy          = value[0];
            REG_PREFETCH_ENABLE: prefetch_enable = value[0];
            default: ;
         endcase
      endfunction

      function bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] c);
         return (c == '1) ? c : c + 1'b1;
      endfunction

      // Make way w the most recent; ranks below its old rank move up, capped at the top.
      function void promote(int base, int w, int n);
         int old;
         old = line_valid[base + w] ? int'(line_rank[base + w]) : MAX_WAYS;
         for (int v = 0; v < n; v++) begin
            if (v != w && line_valid[base + v] && line_rank[base + v] < old
                && line_rank[base + v] < MAX_WAYS - 1)
               line_rank[base + v]++;
         end
         line_rank[base + w] = '0;
      endfunction

      function int find_way(int base, bit [ADDR_BITS-1:0] tag, int n);
         for (int v = 0; v < n; v++)
            if (line_valid[base + v] && line_tag[base + v] == tag) return v;
         return n;
      endfunction

      // First invalid way, else the lowest way holding the largest rank.
      function int fill(int base, bit [ADDR_BITS-1:0] tag, int n);
         int victim;
         int best;
         victim = n;
         for (int v = 0; v < n; v++) begin
            if (!line_valid[base + v]) begin
               victim = v;
               break;
            end
         end
         if (victim == n) begin
            best   = 0;
            victim = 0;
            for (int v = 0; v < n; v++) begin
               if (line_rank[base + v] > best) begin
                  best   = line_rank[base + v];
                  victim = v;
               end
            end
         end
         promote(base, victim, n);
         line_valid[base + victim] = 1'b1;
         line_tag[base + victim]   = tag;
         return victim;
      endfunction

      function void note_access(logic cmd, logic [ADDR_BITS-1:0] address);
         access_outcome      o;
         int                 n;
         int                 sb;
         int                 ob;
         int                 base;
         int                 pbase;
         int                 way;
         bit [63:0]          set_mask;
         bit [ADDR_BITS-1:0] tag;
         bit [ADDR_BITS-1:0] next_addr;
         bit [ADDR_BITS-1:0] ptag;
         n  = (ways_in_use == 0) ? 1 : (ways_in_use > MAX_WAYS ? MAX_WAYS : ways_in_use);
         sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
         ob = offset_bits;
         set_mask = (64'd1 << sb) - 64'd1;
         base = int'(({16'd0, address} >> ob) & set_mask) * MAX_WAYS;
         tag  = address >> (ob + sb);
         o = '{default: 0};
         if (cmd == CMD_WRITE) write_count = sat_inc(write_count);
         way = find_way(base, tag, n);
         if (way < n) begin
            o.hit = 1'b1;
            hit_count = sat_inc(hit_count);
            if (policy == POLICY_LRU) promote(base, way, n);
         end else begin
            miss_count = sat_inc(miss_count);
            read_count = sat_inc(read_count);
            way = fill(base, tag, n);
            if (prefetch_enable) begin
               // next block wraps within the address width
               next_addr = address + ({{(ADDR_BITS-1){1'b0}}, 1'b1} << ob);
               pbase = int'(({16'd0, next_addr} >> ob) & set_mask) * MAX_WAYS;
               ptag  = next_addr >> (ob + sb);
               if (find_way(pbase, ptag, n) == n) begin
                  read_count = sat_inc(read_count);
                  void'(fill(pbase, ptag, n));
                  o.prefetch_read = 1'b1;
               end
            end
         end
         o.way          = way[OUT_WAY_W-1:0];
         o.total_reads  = read_count;
         o.total_writes = write_count;
         o.total_hits   = hit_count;
         o.total_misses = miss_count;
         awaited.push_back(o);
      endfunction

      function void compare_field(string name, bit [CNT_W-1:0] want, bit [CNT_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_outcome(access_outcome got);
         access_outcome want;
         if (awaited.size() == 0) begin
            $error("result beat with no access waiting");
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("hit", want.hit, got.hit);
         compare_field("way", want.way, got.way);
         compare_field("prefetch_read", want.prefetch_read, got.prefetch_read);
         compare_field("total_reads", want.total_reads, got.total_reads);
         compare_field("total_writes", want.total_writes, got.total_writes);
         compare_field("total_hits", want.total_hits, got.total_hits);
         compare_field("total_misses", want.total_misses, got.total_misses);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

endpackage

>>> bench/set_assoc_cache_with_prefetch_core_test.sv
`timescale 1ns / 1ps
// Top-level bench for the set-associative cache: directed and random accesses over
// several register settings, with idling on both channels. Depends on scap_pkg,
// scap_if and scap_bench_pkg.
module set_assoc_cache_with_prefetch_core_test;
   import scap_pkg::*;
   import scap_bench_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 175;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    cur_ob;
   int                    cur_sb;
   int                    cycles_run;
   logic [63:0]           hot_base;
   logic [63:0]           stream_addr;
   access_outcome         seen;
   cache_tracker          tracker = new();

   scap_req_if req_ch ();
   scap_rsp_if rsp_ch ();

   set_assoc_cache_with_prefetch_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.hit           = rsp_ch.hit;
         seen.way           = rsp_ch.way;
         seen.prefetch_read = rsp_ch.prefetch_read;
         seen.total_reads   = rsp_ch.total_reads;
         seen.total_writes  = rsp_ch.total_writes;
         seen.total_hits    = rsp_ch.total_hits;
         seen.total_misses  = rsp_ch.total_misses;
         tracker.check_outcome(seen);
      end
   end

   task automatic send_access(input logic cmd, input logic [ADDR_BITS-1:0] address);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.address <= address;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.note_access(cmd, address);
   endtask

   // Leave psel high; the caller closes the transfer after the last write.
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      tracker.apply_register(idx, value);
   endtask

   // Hold off new accesses until every result beat is in, then reprogram.
   task automatic apply_setting(input int ob, input int sb, input int ways,
                                input logic pol, input logic pf);
      req_ch.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      write_register(REG_OFFSET_BITS, 32'(ob));
      write_register(REG_SET_BITS, 32'(sb));
      write_register(REG_WAYS_IN_USE, 32'(ways));
      write_register(REG_POLICY, 32'(pol));
      write_register(REG_PREFETCH_ENABLE, 32'(pf));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_ob = ob;
      cur_sb = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
   endtask

   // Mostly a small pool of hot blocks, same-set conflicts and a sequential stream.
   function automatic logic [ADDR_BITS-1:0] pick_address();
      logic [63:0] blk;
      logic [63:0] pick;
      int          r;
      blk = 64'd1 << cur_ob;
      r   = $urandom_range(0, 99);
      if (r < 40) begin
         pick = hot_base + blk * $urandom_range(0, 23) + ({32'd0, $urandom} & (blk - 64'd1));
      end else if (r < 60) begin
         pick = hot_base + (64'd1 << (cur_ob + cur_sb)) * $urandom_range(0, 11)
                + blk * $urandom_range(0, 3);
      end else if (r < 85) begin
         stream_addr = stream_addr + blk;
         pick = stream_addr;
      end else begin
         pick = {$urandom, $urandom};
      end
      return pick[ADDR_BITS-1:0];
   endfunction

   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.cmd     <= CMD_READ;
      req_ch.address <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      cur_ob = 4;
      cur_sb = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting: one set, one way
      send_access(CMD_READ, 48'h0);
      send_access(CMD_WRITE, 48'h0);
      send_access(CMD_READ, 48'hFFFF_FFFF_FFFF);
      send_access(CMD_WRITE, 48'h10);

      // two ways over four sets, prefetch on; next block wraps past the top
      apply_setting(4, 2, 2, POLICY_LRU, 1'b1);
      send_access(CMD_READ, 48'h0);
      send_access(CMD_READ, 48'h10);
      send_access(CMD_WRITE, 48'h20);
      send_access(CMD_READ, 48'hFFFF_FFFF_FFFF);
      send_access(CMD_READ, 48'h0);
      send_access(CMD_WRITE, 48'h1000);
      send_access(CMD_WRITE, 48'h2000);
      send_access(CMD_READ, 48'h40);
      send_access(CMD_READ, 48'h1000);
      send_access(CMD_WRITE, 48'h8000_0000_0000);

      // single line: the prefetch evicts the block the demand just filled
      apply_setting(4, 0, 1, POLICY_FIFO, 1'b1);
      send_access(CMD_READ, 48'h100);
      send_access(CMD_READ, 48'h100);
      send_access(CMD_READ, 48'h110);
      send_access(CMD_WRITE, 48'h110);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(4, 3, 4, POLICY_LRU, 1'b0);
            1: apply_setting(6, 2, 2, POLICY_FIFO, 1'b1);
            2: apply_setting(0, 0, 8, POLICY_LRU, 1'b1);
            3: apply_setting(16, 10, 1, POLICY_FIFO, 1'b0);
            4: apply_setting(5, 15, 0, POLICY_LRU, 1'b1);
            5: apply_setting(3, 1, 3, POLICY_FIFO, 1'b1);
            6: apply_setting(31, 4, 15, POLICY_LRU, 1'b1);
            default: apply_setting(2, 4, 5, POLICY_LRU, 1'b0);
         endcase
         if (phase < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 84;
         end else if (phase < 6) begin
            send_idle_pct = 84;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         hot_base    = {$urandom, $urandom};
         stream_addr = hot_base + {32'd0, $urandom};
         repeat (PHASE_ITEMS)
            send_access(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ, pick_address());
      end

      req_ch.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
design/scap_pkg.sv
design/scap_if.sv
design/scap_csr.sv
design/scap_set_unit.sv
design/set_assoc_cache_with_prefetch_core.sv
bench/scap_bench_pkg.sv
bench/set_assoc_cache_with_prefetch_core_test.sv
